// ----- hdl/fbm_pkg.sv -----
// ----------------------------------------------------------------------------
// fbm_pkg: shared types and constants for the flash block map manager
// Status codes, request codes, block classes and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none
package fbm_pkg;
    localparam int MAX_BLOCKS_DEF = 8192;

    typedef enum logic [1:0] {
        REQ_SCAN      = 2'd0,
        REQ_TRANSLATE = 2'd1,
        REQ_ASSIGN    = 2'd2,
        REQ_NONE      = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_BAD     = 2'd0,
        ST_GOOD    = 2'd1,
        ST_USED    = 2'd2,
        ST_NOTUSED = 2'd3
    } t_class;

    typedef enum logic [1:0] {
        RS_OK       = 2'd0,
        RS_NOFREE   = 2'd1,
        RS_RANGE    = 2'd2,
        RS_PARITY   = 2'd3
    } t_rstat;

    localparam logic [0:0] CFG_DS = 1'b0;
    localparam logic [0:0] CFG_BC = 1'b1;
    localparam logic [23:0] ERASED_NUMBER = 24'hffffff;
    localparam logic [7:0]  GOOD_MARK = 8'hff;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_MAPRD,
        S_MAPWT,
        S_MAPCHK,
        S_CLSWT,
        S_SEARCH,
        S_SRCHWT,
        S_SRCHCHK,
        S_OLDRD,
        S_OLDWT,
        S_BIND,
        S_OUT
    } t_state;

    // Result word fields
    typedef struct packed {
        logic [12:0] result_block;
        logic [1:0]  status;
        logic [1:0]  block_class;
        logic        erase_needed;
        logic        write_spare;
        logic [23:0] spare_number;
        logic        spare_parity;
    } t_result;

    // Input word fields
    typedef struct packed {
        logic [1:0]  req_type;
        logic [12:0] physical_block;
        logic [23:0] logical_number;
        logic [7:0]  bad_mark_first;
        logic [7:0]  bad_mark_second;
        logic [7:0]  stored_parity;
    } t_request;
endpackage
`default_nettype wire

// ----- hdl/fbm_stream_if.sv -----
// ----------------------------------------------------------------------------
// fbm_stream_if: valid/ready channel carrying one word
// Generic over the payload type.
// ----------------------------------------------------------------------------
`default_nettype none
interface fbm_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hdl/fbm_tables.sv -----
// ----------------------------------------------------------------------------
// fbm_tables: block status memory and logical map memory
// One port each, registered read data, clear sweep driven by the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none
module fbm_tables
    import fbm_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
    localparam int AW = $clog2(MAX_BLOCKS)
) (
    input  wire logic          i_clk,
    input  wire logic          i_st_we,
    input  wire logic [AW-1:0] i_st_addr,
    input  wire logic [1:0]    i_st_wdata,
    output      logic [1:0]    o_st_rdata,
    input  wire logic          i_mp_we,
    input  wire logic [AW-1:0] i_mp_addr,
    input  wire logic [13:0]   i_mp_wdata,
    output      logic [13:0]   o_mp_rdata
);
    logic [1:0]  r_st_mem [MAX_BLOCKS];
    logic [13:0] r_mp_mem [MAX_BLOCKS];

    always_ff @(posedge i_clk) begin
        if (i_st_we) r_st_mem[i_st_addr] <= i_st_wdata;
        o_st_rdata <= r_st_mem[i_st_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_mp_we) r_mp_mem[i_mp_addr] <= i_mp_wdata;
        o_mp_rdata <= r_mp_mem[i_mp_addr];
    end
endmodule
`default_nettype wire

// ----- hdl/flash_block_map_manager_unit.sv -----
// ----------------------------------------------------------------------------
// flash_block_map_manager_unit: bad block table and logical block map
// Sequencer over a status memory and a map memory.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch (sink) takes one request word: scan, translate or assign.
//   out_ch (source) gives exactly one result word per request.
//   Config writes (i_cfg_we/index/data) only while idle.
// Sequencing: one status port and one map port, both with registered reads.
//   Scan passes S_MAPRD, S_OUT; a mapped translate S_MAPRD, S_MAPWT,
//   S_MAPCHK, S_CLSWT, S_OUT; assign S_MAPRD, S_MAPWT, S_MAPCHK, S_OLDRD,
//   S_BIND, S_OUT; a translate with no block to visit S_MAPRD, S_MAPWT,
//   S_MAPCHK, S_OUT. A translate that allocates walks the status table one
//   block per S_SEARCH/S_SRCHWT/S_SRCHCHK round, up to count - data_start
//   blocks. One request is in flight at a time; in_ch ready is low meanwhile.
// Reset: a clearing pass writes every table entry (status bad, map
//   unmapped), one entry a cycle; no request is taken during it, config
//   writes are.
// Stall: the result stays in the output register until taken; the next
//   request is accepted in the same cycle the result leaves.
// ----------------------------------------------------------------------------
`default_nettype none
module flash_block_map_manager_unit
    import fbm_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    fbm_stream_if.sink   in_ch,
    fbm_stream_if.source out_ch,
    input  wire logic        i_cfg_we,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [13:0] i_cfg_data
);
    localparam int AW = $clog2(MAX_BLOCKS);
    localparam logic [14:0] MAXB = 15'(MAX_BLOCKS);

    t_state r_state, n_state;
    logic [12:0] r_ds;
    logic [13:0] r_bc;
    t_request r_req;
    t_result  r_res;
    logic [14:0] r_k;     // search pointer / clear counter
    logic [14:0] r_left;  // blocks still to visit
    logic [13:0] r_old;
    logic        r_erase;
    logic        r_ovalid;

    logic [14:0] w_count;
    assign w_count = ({1'b0, r_bc} < MAXB) ? {1'b0, r_bc} : MAXB;

    logic [1:0]  w_st_rd;
    logic [13:0] w_mp_rd;
    logic        st_we, mp_we;
    logic [AW-1:0] st_addr, mp_addr;
    logic [1:0]  st_wd;
    logic [13:0] mp_wd;

    fbm_tables #(.MAX_BLOCKS(MAX_BLOCKS)) u_tables (
        .i_clk(i_clk),
        .i_st_we(st_we), .i_st_addr(st_addr), .i_st_wdata(st_wd), .o_st_rdata(w_st_rd),
        .i_mp_we(mp_we), .i_mp_addr(mp_addr), .i_mp_wdata(mp_wd), .o_mp_rdata(w_mp_rd)
    );

    // Request decode
    logic [24:0] w_ln;
    logic        w_ln_ok, w_ph_ok, w_ph_ge_ds, w_par;
    assign w_ln     = {1'b0, r_req.logical_number};
    assign w_ln_ok  = w_ln < {10'd0, w_count};
    assign w_ph_ok  = {2'b0, r_req.physical_block} < w_count;
    assign w_ph_ge_ds = r_req.physical_block >= r_ds;
    assign w_par    = ^r_req.logical_number;
    logic [AW-1:0] w_lidx;
    assign w_lidx = r_req.logical_number[AW-1:0];

    logic w_scan_bad, w_scan_erased, w_scan_parerr;
    assign w_scan_bad    = (r_req.bad_mark_first != GOOD_MARK) ||
                           (r_req.bad_mark_second != GOOD_MARK);
    assign w_scan_erased = r_req.logical_number == ERASED_NUMBER;
    assign w_scan_parerr = r_req.stored_parity != {7'd0, w_par};

    logic w_out_take;
    assign w_out_take = r_ovalid && out_ch.ready;
    assign in_ch.ready = (r_state == S_IDLE) && (!r_ovalid || out_ch.ready);
    assign out_ch.valid = r_ovalid;
    assign out_ch.data  = r_res;

    logic w_accept;
    assign w_accept = in_ch.valid && in_ch.ready;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:   if (r_k == MAXB - 15'd1) n_state = S_IDLE;
            S_IDLE:    if (w_accept) n_state = S_MAPRD;
            S_MAPRD: begin
                unique case (t_req'(r_req.req_type))
                    REQ_SCAN:      n_state = S_OUT;
                    REQ_TRANSLATE: n_state = w_ln_ok ? S_MAPWT : S_OUT;
                    REQ_ASSIGN:    n_state = (w_ln_ok && w_ph_ok) ? S_MAPWT : S_OUT;
                    default:       n_state = S_OUT;
                endcase
            end
            S_MAPWT:   n_state = S_MAPCHK;
            S_MAPCHK: begin
                if (t_req'(r_req.req_type) == REQ_ASSIGN) n_state = S_OLDRD;
                else if (w_mp_rd != 14'h3fff) n_state = S_CLSWT;
                else if (r_left == 15'd0) n_state = S_OUT;
                else n_state = S_SEARCH;
            end
            S_CLSWT:   n_state = S_OUT;
            S_SEARCH:  n_state = S_SRCHWT;
            S_SRCHWT:  n_state = S_SRCHCHK;
            S_SRCHCHK: begin
                if (w_st_rd == ST_GOOD || w_st_rd == ST_NOTUSED) n_state = S_OLDRD;
                else if (r_left == 15'd1) n_state = S_OUT;
                else n_state = S_SEARCH;
            end
            S_OLDRD:   n_state = S_BIND;
            S_OLDWT:   n_state = S_BIND;
            S_BIND:    n_state = S_OUT;
            S_OUT:     n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // Memory control
    always_comb begin
        st_we = 1'b0; mp_we = 1'b0;
        st_addr = r_k[AW-1:0];
        mp_addr = w_lidx;
        st_wd = ST_BAD; mp_wd = 14'h3fff;
        unique case (r_state)
            S_CLEAR: begin
                st_we = 1'b1; mp_we = 1'b1; mp_addr = r_k[AW-1:0];
            end
            S_MAPRD: begin
                if (t_req'(r_req.req_type) == REQ_SCAN && w_ph_ge_ds && w_ph_ok) begin
                    st_we = 1'b1;
                    st_addr = r_req.physical_block[AW-1:0];
                    if (w_scan_bad) st_wd = ST_BAD;
                    else if (w_scan_erased) st_wd = ST_GOOD;
                    else if (w_scan_parerr || !w_ln_ok) st_wd = ST_NOTUSED;
                    else begin
                        st_wd = ST_USED;
                        mp_we = 1'b1;
                        mp_wd = {1'b0, r_req.physical_block};
                    end
                end
            end
            S_MAPCHK: st_addr = w_mp_rd[AW-1:0];
            S_OLDRD: begin
                // retire the old physical block of this logical number
                if (r_old != {1'b0, r_k[12:0]} && {1'b0, r_old} < w_count) begin
                    st_we = 1'b1; st_addr = r_old[AW-1:0]; st_wd = ST_NOTUSED;
                end
            end
            S_BIND: begin
                st_we = 1'b1; st_wd = ST_USED;
                mp_we = 1'b1; mp_wd = {1'b0, r_k[12:0]};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_ds     <= 13'd8;
            r_bc     <= 14'd1024;
            r_ovalid <= 1'b0;
            r_k      <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_DS) r_ds <= i_cfg_data[12:0];
                else r_bc <= i_cfg_data;
            end
            if (w_out_take) r_ovalid <= 1'b0;
            if (r_state == S_OUT) r_ovalid <= 1'b1;
            if (r_state == S_CLEAR) r_k <= r_k + 15'd1;
            if (w_accept) r_req <= in_ch.data;
            unique case (r_state)
                S_MAPRD: begin
                    r_erase <= 1'b0;
                    r_res <= '0;
                    r_res.status <= RS_RANGE;
                    if (t_req'(r_req.req_type) == REQ_ASSIGN)
                        r_k <= {2'b0, r_req.physical_block};
                    else
                        r_k <= (w_ln < {12'd0, r_ds}) ? {2'b0, r_ds} : w_ln[14:0];
                    r_left <= ({2'b0, r_ds} < w_count) ? w_count - {2'b0, r_ds} : 15'd0;
                    if (t_req'(r_req.req_type) == REQ_SCAN && w_ph_ge_ds && w_ph_ok) begin
                        r_res.result_block <= r_req.physical_block;
                        r_res.status <= RS_OK;
                        if (w_scan_bad) r_res.block_class <= ST_BAD;
                        else if (w_scan_erased) r_res.block_class <= ST_GOOD;
                        else if (w_scan_parerr) begin
                            r_res.block_class <= ST_NOTUSED;
                            r_res.status <= RS_PARITY;
                        end else if (!w_ln_ok) r_res.block_class <= ST_NOTUSED;
                        else r_res.block_class <= ST_USED;
                        if (!w_scan_bad && !w_scan_erased && !w_scan_parerr && !w_ln_ok)
                            r_res.status <= RS_RANGE;
                    end
                end
                S_MAPCHK: begin
                    r_old <= w_mp_rd;
                    if (t_req'(r_req.req_type) == REQ_TRANSLATE) begin
                        if (w_mp_rd != 14'h3fff) begin
                            r_res.result_block <= w_mp_rd[12:0];
                            r_res.status <= RS_OK;
                        end else begin
                            r_res.status <= RS_NOFREE;
                        end
                    end
                end
                S_CLSWT: r_res.block_class <= ({1'b0, r_old} < MAXB) ? w_st_rd : ST_BAD;
                S_SRCHCHK: begin
                    if (w_st_rd == ST_NOTUSED) r_erase <= 1'b1;
                    if (w_st_rd != ST_GOOD && w_st_rd != ST_NOTUSED) begin
                        r_left <= r_left - 15'd1;
                        r_k <= (r_k + 15'd1 >= w_count) ? {2'b0, r_ds} : r_k + 15'd1;
                    end
                end
                S_BIND: begin
                    r_res.result_block <= r_k[12:0];
                    r_res.status <= RS_OK;
                    r_res.block_class <= ST_USED;
                    r_res.erase_needed <= r_erase;
                    r_res.write_spare <= 1'b1;
                    r_res.spare_number <= r_req.logical_number;
                    r_res.spare_parity <= w_par;
                end
                default: ;
            endcase
        end
    end

    // Assertions
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !in_ch.ready) else $error("accept while busy");
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |=> r_ovalid) else $error("result lost");
    a_write_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_res.write_spare) |-> (r_res.status == RS_OK))
        else $error("spare write with error status");
    a_clear_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !r_ovalid) else $error("result during clear");
endmodule
`default_nettype wire

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking bench for flash_block_map_manager_unit
// Drives scan, translate and assign words through the request channel. A
// model of its own, with its own status table and logical map, works out
// each result. Results are checked field by field, in order. The bench runs
// several register settings, with random idle gaps on both channels.
// ----------------------------------------------------------------------------
`default_nettype none
module tb;
    import fbm_pkg::*;

    localparam int NBLK = MAX_BLOCKS_DEF;
    localparam logic [13:0] NO_MAP = 14'h3fff;
    localparam int MAX_SHOWN = 10;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [0:0]  cfg_idx = CFG_DS;
    logic [13:0] cfg_dat = '0;

    fbm_stream_if #(.T(t_request)) req_ch ();
    fbm_stream_if #(.T(t_result))  res_ch ();

    flash_block_map_manager_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .in_ch       (req_ch.sink),
        .out_ch      (res_ch.source),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_idx),
        .i_cfg_data  (cfg_dat)
    );

    always #2 i_clk = ~i_clk;

    // Shadow copy of the block tables and registers
    t_class      shadow_class[NBLK];
    logic [13:0] shadow_map[NBLK];
    int unsigned shadow_ds = 8;
    int unsigned shadow_bc = 1024;

    t_result     result_q[$];
    int          mismatch_cnt = 0;

    // Directed words; typed-in results where they are obvious
    typedef struct {
        t_request w;
        bit       typed;
        t_result  r;
    } t_row;
    t_row dir_rows[$];

    // Sender burst state
    int burst_left = 0;

    // Register settings swept by the random part: start block, count, words
    int unsigned ph_ds[8] = '{8,    0,  4,  0, 32,    0, 8191, 5};
    int unsigned ph_bc[8] = '{1024, 64, 48, 16, 33, 8192, 8192, 1};
    int          ph_n[8]  = '{40,  350, 300, 250, 150, 25,  25, 20};

    function automatic int unsigned live_count();
        return (shadow_bc < NBLK) ? shadow_bc : NBLK;
    endfunction

    function automatic logic odd24(logic [23:0] v);
        return ^v;
    endfunction

    function automatic void bind_map(int unsigned phys, int unsigned lnum, int unsigned cnt);
        logic [13:0] old;
        old = shadow_map[lnum];
        if (old != phys && old < cnt)
            shadow_class[old] = ST_NOTUSED;
        shadow_class[phys] = ST_USED;
        shadow_map[lnum] = phys[13:0];
    endfunction

    // Work out the result of one word and update the shadow tables
    function automatic t_result predict_map(t_request w);
        t_result     r;
        int unsigned cnt, ph, ln, k, total, n;
        logic [13:0] m;
        t_class      c;
        bit          found;
        r = '0;
        r.status = RS_RANGE;
        cnt = live_count();
        ph = w.physical_block;
        ln = w.logical_number;
        case (w.req_type)
            REQ_SCAN: begin
                if (ph >= shadow_ds && ph < cnt) begin
                    r.result_block = ph[12:0];
                    r.status = RS_OK;
                    if (w.bad_mark_first != GOOD_MARK || w.bad_mark_second != GOOD_MARK) begin
                        c = ST_BAD;
                    end else if (w.logical_number == ERASED_NUMBER) begin
                        c = ST_GOOD;
                    end else if (w.stored_parity != {7'b0, odd24(w.logical_number)}) begin
                        c = ST_NOTUSED;
                        r.status = RS_PARITY;
                    end else if (ln >= cnt) begin
                        c = ST_NOTUSED;
                        r.status = RS_RANGE;
                    end else begin
                        c = ST_USED;
                        shadow_map[ln] = ph[13:0];
                    end
                    shadow_class[ph] = c;
                    r.block_class = c;
                end
            end
            REQ_TRANSLATE: begin
                if (ln < cnt) begin
                    m = shadow_map[ln];
                    if (m != NO_MAP) begin
                        r.result_block = m[12:0];
                        r.status = RS_OK;
                        r.block_class = (m < NBLK) ? shadow_class[m] : ST_BAD;
                    end else begin
                        // Walk the table from the logical number, wrap to the data start
                        k = (ln < shadow_ds) ? shadow_ds : ln;
                        total = (shadow_ds < cnt) ? cnt - shadow_ds : 0;
                        found = 1'b0;
                        for (n = 0; n < total; n++) begin
                            if (shadow_class[k] == ST_GOOD) begin
                                found = 1'b1;
                                break;
                            end
                            if (shadow_class[k] == ST_NOTUSED) begin
                                r.erase_needed = 1'b1;
                                found = 1'b1;
                                break;
                            end
                            k++;
                            if (k >= cnt)
                                k = shadow_ds;
                        end
                        if (found) begin
                            bind_map(k, ln, cnt);
                            r.result_block = k[12:0];
                            r.status = RS_OK;
                            r.block_class = ST_USED;
                            r.write_spare = 1'b1;
                            r.spare_number = w.logical_number;
                            r.spare_parity = odd24(w.logical_number);
                        end else begin
                            r.status = RS_NOFREE;
                        end
                    end
                end
            end
            REQ_ASSIGN: begin
                if (ph < cnt && ln < cnt) begin
                    bind_map(ph, ln, cnt);
                    r.result_block = ph[12:0];
                    r.status = RS_OK;
                    r.block_class = ST_USED;
                    r.write_spare = 1'b1;
                    r.spare_number = w.logical_number;
                    r.spare_parity = odd24(w.logical_number);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic t_request make_word(t_req rq, int unsigned ph, int unsigned ln,
                                           int unsigned m1, int unsigned m2, int unsigned sp);
        t_request w;
        w.req_type = rq;
        w.physical_block = ph[12:0];
        w.logical_number = ln[23:0];
        w.bad_mark_first = m1[7:0];
        w.bad_mark_second = m2[7:0];
        w.stored_parity = sp[7:0];
        return w;
    endfunction

    function automatic t_result short_result(int unsigned blk, t_rstat s, t_class c);
        t_result r;
        r = '0;
        r.result_block = blk[12:0];
        r.status = s;
        r.block_class = c;
        return r;
    endfunction

    function automatic void add_row(t_request w, bit typed, t_result r);
        t_row row;
        row.w = w;
        row.typed = typed;
        row.r = r;
        dir_rows.push_back(row);
    endfunction

    // Random word: mostly well-formed requests inside the current window
    function automatic t_request random_word();
        int unsigned cnt, sel, lo, ph, ln, m1, m2, sp;
        t_req rq;
        cnt = live_count();
        lo = (shadow_ds < cnt) ? shadow_ds : 0;
        sel = $urandom_range(0, 99);
        ph = $urandom_range(lo, cnt - 1);
        ln = $urandom_range(0, cnt - 1);
        m1 = 8'hff;
        m2 = 8'hff;
        if (sel < 45) begin
            rq = REQ_SCAN;
            case ($urandom_range(0, 9))
                0: m1 = $urandom_range(0, 255);
                1: m2 = $urandom_range(0, 255);
                2: ln = ERASED_NUMBER;
                3: ln = $urandom_range(0, 24'hffffff);
                default: ;
            endcase
            sp = odd24(ln[23:0]);
            if ($urandom_range(0, 7) == 0)
                sp = $urandom_range(0, 255);
        end else if (sel < 75) begin
            rq = REQ_TRANSLATE;
            sp = $urandom_range(0, 255);
        end else if (sel < 93) begin
            rq = REQ_ASSIGN;
            sp = $urandom_range(0, 255);
        end else begin
            // noise: any code, any field
            rq = t_req'($urandom_range(0, 3));
            ph = $urandom_range(0, NBLK - 1);
            ln = $urandom_range(0, 24'hffffff);
            m1 = $urandom_range(0, 255);
            m2 = $urandom_range(0, 255);
            sp = $urandom_range(0, 255);
        end
        return make_word(rq, ph, ln, m1, m2, sp);
    endfunction

    // Offer one word at this falling edge, hold it until taken, log its result
    task automatic send_word(t_request w, bit typed, t_result tr);
        t_result r;
        req_ch.data = w;
        req_ch.valid = 1'b1;
        @(posedge i_clk);
        while (!req_ch.ready)
            @(posedge i_clk);
        r = predict_map(w);
        result_q.push_back(typed ? tr : r);
        @(negedge i_clk);
    endtask

    // Burst/gap pacing of the sender; now and then hold off until drained
    task automatic pace_sender();
        int gap;
        if ($urandom_range(0, 59) == 0) begin
            req_ch.valid = 1'b0;
            while (result_q.size() != 0)
                @(negedge i_clk);
        end
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3);
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 12);
        end
        burst_left--;
    endtask

    task automatic drain();
        req_ch.valid = 1'b0;
        while (result_q.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [0:0] idx, int unsigned val);
        cfg_we = 1'b1;
        cfg_idx = idx;
        cfg_dat = val[13:0];
        @(negedge i_clk);
        cfg_we = 1'b0;
        if (idx == CFG_DS)
            shadow_ds = val & 32'h1fff;
        else
            shadow_bc = val & 32'h3fff;
    endtask

    // Receiver: a stall pattern, redrawn whenever rx_left runs out
    int rx_mode = 0;
    int rx_left = 0;
    int unsigned rx_tick = 0;
    initial res_ch.ready = 1'b0;
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = 64;
        end
        rx_left--;
        rx_tick++;
        case (rx_mode)
            0: res_ch.ready = 1'b1;
            1: res_ch.ready = ($urandom_range(0, 3) != 0);
            2: res_ch.ready = ($urandom_range(0, 3) == 0);
            default: res_ch.ready = rx_tick[2];
        endcase
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        t_result exp_r, got;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got = res_ch.data;
            if (result_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= MAX_SHOWN)
                    $display("unexpected result word %h", got);
            end else begin
                exp_r = result_q.pop_front();
                if (got.result_block !== exp_r.result_block || got.status !== exp_r.status
                    || got.block_class !== exp_r.block_class
                    || got.erase_needed !== exp_r.erase_needed
                    || got.write_spare !== exp_r.write_spare
                    || got.spare_number !== exp_r.spare_number
                    || got.spare_parity !== exp_r.spare_parity) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_SHOWN)
                        $display({"result differs: exp blk=%0d st=%0d cls=%0d er=%0b ws=%0b",
                                  " num=%h par=%0b / got blk=%0d st=%0d cls=%0d er=%0b",
                                  " ws=%0b num=%h par=%0b"},
                            exp_r.result_block, exp_r.status, exp_r.block_class,
                            exp_r.erase_needed, exp_r.write_spare, exp_r.spare_number,
                            exp_r.spare_parity, got.result_block, got.status,
                            got.block_class, got.erase_needed, got.write_spare,
                            got.spare_number, got.spare_parity);
                end
            end
        end
    end

    // Watchdog
    initial begin
        #20000000;
        $display("flash_block_map_manager_unit: mismatch");
        $finish;
    end

    initial begin
        t_row row;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        for (int i = 0; i < NBLK; i++) begin
            shadow_class[i] = ST_BAD;
            shadow_map[i] = NO_MAP;
        end

        // Directed words, at the reset settings: start 8, count 1024
        add_row(make_word(REQ_TRANSLATE, 0, 0, 'hff, 'hff, 0), 1,
                short_result(0, RS_NOFREE, ST_BAD));
        add_row(make_word(REQ_SCAN, 3, 0, 'hff, 'hff, 0), 1,
                short_result(0, RS_RANGE, ST_BAD));
        add_row(make_word(REQ_SCAN, 1024, 1, 'hff, 'hff, 1), 1,
                short_result(0, RS_RANGE, ST_BAD));
        add_row(make_word(REQ_SCAN, 8191, 'hffffff, 'hff, 'hff, 0), 1,
                short_result(0, RS_RANGE, ST_BAD));
        add_row(make_word(REQ_SCAN, 8, 'hffffff, 'h00, 'hff, 0), 1,
                short_result(8, RS_OK, ST_BAD));
        add_row(make_word(REQ_SCAN, 9, 'hffffff, 'hff, 'h7f, 0), 1,
                short_result(9, RS_OK, ST_BAD));
        add_row(make_word(REQ_SCAN, 10, 'hffffff, 'hff, 'hff, 'hff), 1,
                short_result(10, RS_OK, ST_GOOD));
        add_row(make_word(REQ_SCAN, 11, 5, 'hff, 'hff, 1), 1,
                short_result(11, RS_PARITY, ST_NOTUSED));
        add_row(make_word(REQ_SCAN, 12, 1, 'hff, 'hff, 'hff), 1,
                short_result(12, RS_PARITY, ST_NOTUSED));
        add_row(make_word(REQ_SCAN, 13, 2000, 'hff, 'hff, 0), 0, '0);
        add_row(make_word(REQ_SCAN, 1023, 0, 'hff, 'hff, 0), 0, '0);
        add_row(make_word(REQ_SCAN, 14, 'hfffffe, 'hff, 'hff, 1), 0, '0);
        add_row(make_word(REQ_TRANSLATE, 0, 0, 0, 0, 0), 0, '0);
        add_row(make_word(REQ_TRANSLATE, 0, 1024, 0, 0, 0), 1,
                short_result(0, RS_RANGE, ST_BAD));
        add_row(make_word(REQ_TRANSLATE, 8191, 'hffffff, 'hff, 'hff, 'hff), 1,
                short_result(0, RS_RANGE, ST_BAD));
        add_row(make_word(REQ_TRANSLATE, 0, 3, 0, 0, 0), 0, '0);
        add_row(make_word(REQ_TRANSLATE, 0, 20, 0, 0, 0), 0, '0);
        add_row(make_word(REQ_ASSIGN, 1023, 7, 0, 0, 0), 0, '0);
        add_row(make_word(REQ_ASSIGN, 0, 7, 0, 0, 0), 0, '0);
        add_row(make_word(REQ_TRANSLATE, 0, 7, 0, 0, 0), 0, '0);
        add_row(make_word(REQ_ASSIGN, 1024, 0, 0, 0, 0), 1,
                short_result(0, RS_RANGE, ST_BAD));
        add_row(make_word(REQ_ASSIGN, 5, 'hffffff, 0, 0, 0), 1,
                short_result(0, RS_RANGE, ST_BAD));
        add_row(make_word(REQ_NONE, 8191, 'hffffff, 'hff, 'hff, 'hff), 1,
                short_result(0, RS_RANGE, ST_BAD));

        // Hold reset, release at a falling edge
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Walk the directed table back to back
        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            send_word(row.w, row.typed, row.r);
        end

        // Random phases, one register setting each
        for (int p = 0; p < 8; p++) begin
            drain();
            write_reg(CFG_DS, ph_ds[p]);
            write_reg(CFG_BC, ph_bc[p]);
            burst_left = 0;
            for (int i = 0; i < ph_n[p]; i++) begin
                pace_sender();
                send_word(random_word(), 1'b0, '0);
            end
        end

        drain();
        repeat (40) @(posedge i_clk);
        if (mismatch_cnt == 0 && result_q.size() == 0) begin
            $display("flash_block_map_manager_unit: match");
        end else begin
            $display("flash_block_map_manager_unit: mismatch");
        end
        $finish;
    end
endmodule
`default_nettype wire
